FILE: design/agcm_pkg.sv
// ----------------------------------------------------------------------------
// agcm_pkg: shared types and constants of the AES-128-GCM engine
// S-box function, AES round helpers, queue entry and back-end state types.
// ----------------------------------------------------------------------------
package agcm_pkg;

   typedef enum logic [1:0] {
      FUNC_AAD    = 2'd0,
      FUNC_TEXT   = 2'd1,
      FUNC_FINISH = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   // Back-end sequencer states
   typedef enum logic [2:0] {
      ST_IDLE, ST_KEYS, ST_HKEY, ST_AES, ST_HASH, ST_OUT
   } st_type;

   localparam logic [2:0] CSR_KEY_HIGH   = 3'd0;
   localparam logic [2:0] CSR_KEY_LOW    = 3'd1;
   localparam logic [2:0] CSR_NONCE_HIGH = 3'd2;
   localparam logic [2:0] CSR_NONCE_LOW  = 3'd3;
   localparam logic [2:0] CSR_MODE       = 3'd4;

   localparam logic [7:0] GF_POLY = 8'h1b;
   localparam logic [7:0] GH_R    = 8'hE1;

   // Queue entry between the front and back parts
   typedef struct packed {
      func_type     func;
      logic [127:0] data;
      logic [127:0] mask;
      logic [4:0]   count;
   } job_type;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[a];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
   endfunction

   // Byte i of a block sits at bits 127-8i downto 120-8i
   function automatic logic [7:0] bget(input logic [127:0] s, input int i);
      return s[127 - 8*i -: 8];
   endfunction

   // SubBytes and ShiftRows
   function automatic logic [127:0] sub_shift(input logic [127:0] s);
      logic [127:0] t;
      t = '0;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            t[127 - 8*(r + 4*c) -: 8] = sbox(bget(s, r + 4*((c + r) % 4)));
      return t;
   endfunction

   function automatic logic [127:0] mix_cols(input logic [127:0] s);
      logic [127:0] t;
      logic [7:0]   a0, a1, a2, a3, al;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         a0 = bget(s, 4*c); a1 = bget(s, 4*c+1);
         a2 = bget(s, 4*c+2); a3 = bget(s, 4*c+3);
         al = a0 ^ a1 ^ a2 ^ a3;
         t[127 - 32*c -: 8]  = a0 ^ al ^ xtime(a0 ^ a1);
         t[119 - 32*c -: 8]  = a1 ^ al ^ xtime(a1 ^ a2);
         t[111 - 32*c -: 8]  = a2 ^ al ^ xtime(a2 ^ a3);
         t[103 - 32*c -: 8]  = a3 ^ al ^ xtime(a3 ^ a0);
      end
      return t;
   endfunction

   // One key schedule step
   function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
      t  = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
      w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

endpackage

FILE: design/agcm_front.sv
// ----------------------------------------------------------------------------
// agcm_front: request intake
// Drops unused requests, saturates the count, masks the data and queues jobs.
// ----------------------------------------------------------------------------
module agcm_front import agcm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [1:0]    req_func,
   input  logic [127:0]  req_data,
   input  logic [4:0]    req_count,
   output logic          job_valid,
   input  logic          job_take,
   output job_type       job
);
   localparam int Depth = 2;

   job_type     q_ff [Depth];
   job_type     q_in;
   logic        wp_ff, rp_ff;
   logic [1:0]  cnt_ff;
   logic [4:0]  n;
   logic        push, pop, keep;

   assign req_tready = (cnt_ff != 2'd2);
   assign job_valid  = (cnt_ff != 2'd0);
   assign job        = q_ff[rp_ff];

   // classify and mask
   always_comb begin
      n = (req_count > 5'd16) ? 5'd16 : req_count;
      q_in.func  = func_type'(req_func);
      q_in.count = n;
      for (int i = 0; i < 16; i++)
         q_in.mask[127 - 8*i -: 8] = (5'(i) < n) ? 8'hff : 8'h00;
      if (req_func == FUNC_FINISH) q_in.mask = '1;
      q_in.data = req_data & q_in.mask;
      keep = (req_func == FUNC_FINISH) ||
             ((req_func != FUNC_NONE) && (req_count != 5'd0));
   end

   assign push = req_tvalid && req_tready && keep;
   assign pop  = job_valid && job_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= q_in;
   end
endmodule

FILE: design/agcm_back.sv
// ----------------------------------------------------------------------------
// agcm_back: AES round engine, GHASH and result register
// One AES round per cycle, GHASH 8 bits per cycle, key schedule on demand.
// ----------------------------------------------------------------------------
module agcm_back import agcm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic [127:0]  key,
   input  logic          key_wr,
   input  logic [95:0]   nonce,
   input  logic          encrypt_mode,
   input  logic          job_valid,
   output logic          job_take,
   input  job_type       job,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [129:0]  rsp_bits
);
   st_type        st_ff, st_in;
   logic [127:0]  rk_ff [11];
   logic [127:0]  kcur_ff;
   logic [7:0]    rcon_ff;
   logic [3:0]    rnd_ff;
   logic [127:0]  s_ff, h_ff, acc_ff, z_ff, v_ff, x_ff;
   logic [3:0]    gi_ff;
   logic          kr_ff;
   logic [31:0]   ctr_ff, aad_ff, txt_ff;
   job_type       j_ff;
   logic          ov_ff;
   logic [129:0]  ob_ff;
   logic [127:0]  res, zn, vn, ks;
   logic [7:0]    xb;

   assign rsp_tvalid = ov_ff;
   assign rsp_bits   = ob_ff;
   assign job_take   = (st_ff == ST_IDLE) && !ov_ff;
   assign ks         = rk_ff[rnd_ff];

   // GHASH 8 bits per cycle, MSB first
   always_comb begin
      zn = z_ff; vn = v_ff;
      xb = x_ff[127:120];
      for (int b = 0; b < 8; b++) begin
         if (xb[7 - b]) zn = zn ^ vn;
         vn = {1'b0, vn[127:1]} ^ (vn[0] ? {GH_R, 120'd0} : 128'd0);
      end
      res = s_ff ^ j_ff.data;
   end

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: if (job_valid && !ov_ff) st_in = kr_ff ? ST_AES : ST_KEYS;
         ST_KEYS: if (rnd_ff == 4'd10) st_in = ST_HKEY;
         ST_HKEY: if (rnd_ff == 4'd10) st_in = ST_AES;
         ST_AES:  if (rnd_ff == 4'd10) st_in = ST_HASH;
         ST_HASH: if (gi_ff == 4'd15) st_in = ST_OUT;
         ST_OUT:  st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; kr_ff <= 1'b0; ov_ff <= 1'b0;
         acc_ff <= '0; ctr_ff <= 32'd2; aad_ff <= '0; txt_ff <= '0;
      end else begin
         st_ff <= st_in;
         if (ov_ff && rsp_tready) ov_ff <= 1'b0;
         case (st_ff)
            ST_IDLE: begin
               if (job_valid && !ov_ff) begin
                  j_ff <= job; rnd_ff <= 4'd0;
                  kcur_ff <= key; rcon_ff <= 8'h01;
                  // pre-whitened input for the round engine
                  if (kr_ff)
                     s_ff <= {nonce, (job.func == FUNC_FINISH) ? 32'd1 : ctr_ff} ^ rk_ff[0];
               end
            end
            ST_KEYS: begin
               rk_ff[rnd_ff] <= kcur_ff;
               kcur_ff <= key_step(kcur_ff, rcon_ff);
               rcon_ff <= xtime(rcon_ff);
               rnd_ff  <= (rnd_ff == 4'd10) ? 4'd1 : rnd_ff + 4'd1;
               if (rnd_ff == 4'd10) s_ff <= rk_ff[0];
            end
            ST_HKEY, ST_AES: begin
               if (rnd_ff == 4'd0) begin
                  s_ff <= {nonce, (j_ff.func == FUNC_FINISH) ? 32'd1 : ctr_ff} ^ rk_ff[0];
                  rnd_ff <= 4'd1;
               end else if (rnd_ff == 4'd10) begin
                  s_ff <= sub_shift(s_ff) ^ ks;
                  rnd_ff <= (st_ff == ST_HKEY) ? 4'd0 : 4'd1;
                  if (st_ff == ST_HKEY) begin
                     h_ff <= sub_shift(s_ff) ^ ks;
                  end else begin
                     // load the GHASH operand
                     gi_ff <= 4'd0; z_ff <= '0; v_ff <= h_ff;
                     case (j_ff.func)
                        FUNC_AAD:  x_ff <= acc_ff ^ j_ff.data;
                        FUNC_TEXT: x_ff <= acc_ff ^ (encrypt_mode ?
                                   ((sub_shift(s_ff) ^ ks ^ j_ff.data) & j_ff.mask) :
                                   j_ff.data);
                        default:   x_ff <= acc_ff ^ {29'd0, aad_ff, 3'd0, 29'd0, txt_ff, 3'd0};
                     endcase
                  end
               end else begin
                  s_ff <= mix_cols(sub_shift(s_ff)) ^ ks;
                  rnd_ff <= rnd_ff + 4'd1;
               end
            end
            ST_HASH: begin
               z_ff <= zn; v_ff <= vn; x_ff <= {x_ff[119:0], 8'd0};
               gi_ff <= gi_ff + 4'd1;
               if (gi_ff == 4'd15) acc_ff <= zn;
            end
            ST_OUT: begin
               case (j_ff.func)
                  FUNC_AAD: aad_ff <= aad_ff + 32'(j_ff.count);
                  FUNC_TEXT: begin
                     ctr_ff <= ctr_ff + 32'd1;
                     txt_ff <= txt_ff + 32'(j_ff.count);
                     ov_ff <= 1'b1;
                     ob_ff <= {1'b0, res & j_ff.mask, 1'b0};
                  end
                  default: begin
                     ov_ff <= 1'b1;
                     ob_ff <= {!encrypt_mode && ((s_ff ^ acc_ff) == j_ff.data),
                               s_ff ^ acc_ff, 1'b1};
                     acc_ff <= '0; ctr_ff <= 32'd2; aad_ff <= '0; txt_ff <= '0;
                  end
               endcase
            end
            default: ;
         endcase
         // key writes invalidate the schedule; otherwise it becomes valid once built
         if (key_wr) kr_ff <= 1'b0;
         else if (st_ff == ST_KEYS && rnd_ff == 4'd10) kr_ff <= 1'b1;
      end
   end
endmodule

FILE: design/aes128_gcm_engine.sv
// ----------------------------------------------------------------------------
// aes128_gcm_engine: AES-128-GCM block engine, 96-bit nonce
// Front intake and queue, back round engine with GHASH.
// ----------------------------------------------------------------------------
// Every AAD, text or finish request passes through the back end in order: it
// is taken from the queue, runs the iterative AES round unit (counter block
// load plus ten rounds, one per cycle), then the GHASH multiplier (8 bits
// per cycle), and a last step registers the response. After a key write, the
// first request also runs the key schedule and the hash subkey. A response
// waiting on rsp_tready holds the engine; up to two requests queue in front
// of it. AAD requests produce no response.
module aes128_gcm_engine import agcm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // tdata: data_high[63:0], data_low[127:64], byte_count[132:128], pad
   input  logic [135:0]  req_tdata,
   // tuser: func[1:0]
   input  logic [1:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // tdata: out_high[63:0], out_low[127:64], tag_match[128], pad
   output logic [135:0]  rsp_tdata,
   // tuser: is_tag
   output logic          rsp_tuser,
   input  logic          csr_we,
   input  logic [2:0]    csr_index,
   input  logic [63:0]   csr_wdata
);
   logic [63:0]  key_high_ff, key_low_ff, nonce_high_ff;
   logic [31:0]  nonce_low_ff;
   logic         mode_ff, job_valid, job_take;
   job_type      job;
   logic [129:0] rb;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0; key_low_ff <= '0; nonce_high_ff <= '0;
         nonce_low_ff <= '0; mode_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_KEY_HIGH:   key_high_ff <= csr_wdata;
            CSR_KEY_LOW:    key_low_ff <= csr_wdata;
            CSR_NONCE_HIGH: nonce_high_ff <= csr_wdata;
            CSR_NONCE_LOW:  nonce_low_ff <= csr_wdata[31:0];
            CSR_MODE:       mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   agcm_front u_front (
      .clock, .reset, .req_tvalid, .req_tready,
      .req_func  (req_tuser),
      .req_data  ({req_tdata[63:0], req_tdata[127:64]}),
      .req_count (req_tdata[132:128]),
      .job_valid, .job_take, .job
   );

   agcm_back u_back (
      .clock, .reset,
      .key          ({key_high_ff, key_low_ff}),
      .key_wr       (csr_we && (csr_index == CSR_KEY_HIGH || csr_index == CSR_KEY_LOW)),
      .nonce        ({nonce_high_ff, nonce_low_ff}),
      .encrypt_mode (mode_ff),
      .job_valid, .job_take, .job,
      .rsp_tvalid, .rsp_tready,
      .rsp_bits     (rb)
   );

   assign rsp_tuser = rb[0];
   assign rsp_tdata = {7'd0, rb[129], rb[64:1], rb[128:65]};

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped while stalled");
   a_match: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> !rsp_tdata[128])
      else $error("tag match on text result");
   a_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> job_valid)
      else $error("queue stalls while empty");
endmodule

FILE: test/aes128_gcm_engine_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aes128_gcm_engine_test: self-checking bench for the AES-128-GCM engine
// Drives AAD, text and finish requests under random flow control, predicts
// every text block and tag with an independent GCM model and checks each
// response field by field. Key, nonce and direction change between phases.
// ----------------------------------------------------------------------------
module aes128_gcm_engine_test;
   import agcm_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 150;

   typedef struct {
      func_type    func;
      logic [63:0] dh;
      logic [63:0] dl;
      logic [4:0]  cnt;
   } request_type;

   typedef struct {
      logic         is_tag;
      logic [127:0] blk;
      logic         match;
   } response_type;

   // Per-message GHASH state
   typedef struct {
      logic [127:0] acc;
      logic [31:0]  ctr;
      logic [31:0]  aad_bytes;
      logic [31:0]  text_bytes;
   } message_type;

   typedef logic [127:0] round_keys_type [11];

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [135:0]  req_tdata;
   logic [1:0]    req_tuser;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [135:0]  rsp_tdata;
   logic          rsp_tuser;
   logic          csr_we;
   logic [2:0]    csr_index;
   logic [63:0]   csr_wdata;

   aes128_gcm_engine DUT (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_we, .csr_index, .csr_wdata
   );

   // Model copies of configuration and derived keys
   logic [7:0]     sub_byte [256];
   logic [127:0]   aes_key;
   logic [95:0]    nonce;
   logic           encrypting;
   round_keys_type round_keys;
   logic [127:0]   gh_subkey;
   message_type    msg;

   request_type  pending_requests [$];
   response_type expected_responses [$];
   int           fail_count;
   int           responses_seen;
   int           cycle_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] gmul8(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = '0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      end
      return p;
   endfunction

   // S-box from the field inverse and the affine map
   function automatic void build_sub_bytes();
      logic [7:0] inv;
      for (int a = 0; a < 256; a++) begin
         inv = '0;
         for (int b = 1; b < 256; b++)
            if (a != 0 && gmul8(8'(a), 8'(b)) == 8'h01) inv = 8'(b);
         sub_byte[a] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                     ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      end
   endfunction

   function automatic round_keys_type expand_key(input logic [127:0] k);
      round_keys_type rk;
      logic [31:0] w [4];
      logic [31:0] t;
      logic [7:0]  rc;
      rk[0] = k;
      rc = 8'h01;
      for (int r = 1; r <= 10; r++) begin
         for (int j = 0; j < 4; j++) w[j] = rk[r-1][127 - 32*j -: 32];
         t = {sub_byte[w[3][23:16]] ^ rc, sub_byte[w[3][15:8]],
              sub_byte[w[3][7:0]], sub_byte[w[3][31:24]]};
         w[0] ^= t;
         for (int j = 1; j < 4; j++) w[j] ^= w[j-1];
         rk[r] = {w[0], w[1], w[2], w[3]};
         rc = gmul8(rc, 8'h02);
      end
      return rk;
   endfunction

   // Byte i lives at bits 127-8i; state column c holds bytes 4c..4c+3
   function automatic logic [127:0] sub_and_shift(input logic [127:0] s);
      logic [127:0] o;
      for (int i = 0; i < 16; i++)
         o[127 - 8*i -: 8] = sub_byte[s[127 - 8*((i % 4) + 4*(((i / 4) + (i % 4)) % 4)) -: 8]];
      return o;
   endfunction

   function automatic logic [127:0] mix_columns(input logic [127:0] s);
      logic [127:0] o;
      logic [7:0]   a [4];
      for (int c = 0; c < 4; c++) begin
         for (int j = 0; j < 4; j++) a[j] = s[127 - 32*c - 8*j -: 8];
         for (int j = 0; j < 4; j++)
            o[127 - 32*c - 8*j -: 8] = gmul8(a[j], 8'h02) ^ gmul8(a[(j+1)%4], 8'h03)
                                     ^ a[(j+2)%4] ^ a[(j+3)%4];
      end
      return o;
   endfunction

   function automatic logic [127:0] aes_encrypt(input logic [127:0] blk);
      logic [127:0] s;
      s = blk ^ round_keys[0];
      for (int r = 1; r < 10; r++) s = mix_columns(sub_and_shift(s)) ^ round_keys[r];
      return sub_and_shift(s) ^ round_keys[10];
   endfunction

   // GF(2^128) product, MSB first, reduction by E1
   function automatic logic [127:0] gf_mult(input logic [127:0] x, input logic [127:0] h);
      logic [127:0] z, v;
      z = '0;
      v = h;
      for (int i = 0; i < 128; i++) begin
         if (x[127 - i]) z ^= v;
         v = v[0] ? ((v >> 1) ^ {8'hE1, 120'b0}) : (v >> 1);
      end
      return z;
   endfunction

   function automatic void clear_message(inout message_type m);
      m.acc = '0;
      m.ctr = 32'd2;
      m.aad_bytes = '0;
      m.text_bytes = '0;
   endfunction

   // Advances one message by a request; returns 1 if it yields a response
   function automatic bit gcm_step(inout message_type m, input request_type rq,
                                   output response_type rs);
      logic [127:0] din, mask, ks;
      int n;
      din = {rq.dh, rq.dl};
      rs = '{1'b0, '0, 1'b0};
      if (rq.func == FUNC_NONE) return 0;
      if (rq.func == FUNC_FINISH) begin
         m.acc = gf_mult(m.acc ^ {29'b0, m.aad_bytes, 3'b0, 29'b0, m.text_bytes, 3'b0},
                         gh_subkey);
         rs.is_tag = 1'b1;
         rs.blk = aes_encrypt({nonce, 32'd1}) ^ m.acc;
         rs.match = !encrypting && rs.blk == din;
         clear_message(m);
         return 1;
      end
      if (rq.cnt == 0) return 0;
      n = (rq.cnt > 16) ? 16 : rq.cnt;
      mask = ~128'b0 << (128 - 8*n);
      din &= mask;
      if (rq.func == FUNC_AAD) begin
         m.acc = gf_mult(m.acc ^ din, gh_subkey);
         m.aad_bytes += 32'(n);
         return 0;
      end
      ks = (aes_encrypt({nonce, m.ctr}) ^ din) & mask;
      m.acc = gf_mult(m.acc ^ (encrypting ? ks : din), gh_subkey);
      m.ctr += 32'd1;
      m.text_bytes += 32'(n);
      rs.blk = ks;
      return 1;
   endfunction

   // Tag of a whole message from a cleared state
   function automatic logic [127:0] message_tag(input request_type items [$]);
      message_type  m;
      response_type rs;
      request_type  fin;
      clear_message(m);
      foreach (items[i]) void'(gcm_step(m, items[i], rs));
      fin = '{FUNC_FINISH, '0, '0, 5'd0};
      void'(gcm_step(m, fin, rs));
      return rs.blk;
   endfunction

   // Sender: bursts and gaps; prediction at acceptance
   request_type on_bus;
   int burst_left, gap_left;
   always @(posedge clock) begin
      response_type rs;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tuser <= '0;
         burst_left = 4;
         gap_left = 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid && gcm_step(msg, on_bus, rs)) expected_responses.push_back(rs);
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            on_bus = pending_requests.pop_front();
            req_tdata <= {3'b0, on_bus.cnt, on_bus.dl, on_bus.dh};
            req_tuser <= on_bus.func;
            req_tvalid <= 1'b1;
            if (--burst_left <= 0) begin
               burst_left = $urandom_range(1, 30);
               gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 25) : 0;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: stall pattern by cycle window, plus one long hold-off
   int  hold_left;
   bit  held_once;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left = 0;
         held_once = 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!held_once && responses_seen >= 100) begin
         held_once = 1;
         hold_left = 600;
         rsp_tready <= 1'b0;
      end else begin
         case (cycle_count[10:9])
            2'd0: rsp_tready <= 1'b1;
            2'd1: rsp_tready <= $urandom_range(0, 1);
            2'd2: rsp_tready <= ($urandom_range(0, 7) != 0);
            default: rsp_tready <= ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   // Response checker
   always @(posedge clock) begin
      response_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         responses_seen++;
         if (expected_responses.size() == 0) begin
            $error("unexpected response %h", rsp_tdata);
            fail_count++;
         end else begin
            want = expected_responses.pop_front();
            if (rsp_tuser !== want.is_tag) begin
               $error("is_tag: expected %b, got %b", want.is_tag, rsp_tuser);
               fail_count++;
            end
            if (rsp_tdata[63:0] !== want.blk[127:64]) begin
               $error("out_high: expected %h, got %h", want.blk[127:64], rsp_tdata[63:0]);
               fail_count++;
            end
            if (rsp_tdata[127:64] !== want.blk[63:0]) begin
               $error("out_low: expected %h, got %h", want.blk[63:0], rsp_tdata[127:64]);
               fail_count++;
            end
            if (rsp_tdata[128] !== want.match) begin
               $error("tag_match: expected %b, got %b", want.match, rsp_tdata[128]);
               fail_count++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic write_csr(input logic [2:0] idx, input logic [63:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_KEY_HIGH:   aes_key[127:64] = value;
         CSR_KEY_LOW:    aes_key[63:0] = value;
         CSR_NONCE_HIGH: nonce[95:32] = value;
         CSR_NONCE_LOW:  nonce[31:0] = value[31:0];
         CSR_MODE:       encrypting = value[0];
         default: ;
      endcase
      round_keys = expand_key(aes_key);
      gh_subkey = aes_encrypt('0);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_requests.size() > 0 || req_tvalid || expected_responses.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic request_type make_request(input func_type f, input int cnt_lo,
                                                input int cnt_hi);
      request_type rq;
      rq.func = f;
      rq.dh = {$urandom, $urandom};
      rq.dl = {$urandom, $urandom};
      rq.cnt = 5'($urandom_range(cnt_lo, cnt_hi));
      return rq;
   endfunction

   // Finish request; in decrypt mode usually carries the true tag
   function automatic request_type finish_for(input request_type items [$]);
      request_type rq;
      logic [127:0] tag;
      rq = make_request(FUNC_FINISH, 0, 31);
      if (!encrypting && $urandom_range(0, 9) < 7) begin
         tag = message_tag(items);
         if ($urandom_range(0, 6) == 0) tag[$urandom_range(0, 127)] ^= 1'b1;
         {rq.dh, rq.dl} = tag;
      end
      return rq;
   endfunction

   // Well-formed messages with random content and some noise
   task automatic random_messages(input int budget);
      request_type items [$];
      request_type rq;
      int n_aad, n_text, used;
      used = 0;
      while (used < budget) begin
         items.delete();
         n_aad = $urandom_range(0, 3);
         n_text = $urandom_range(0, 6);
         while (n_aad + n_text > 0) begin
            if (n_text == 0 || (n_aad > 0 && $urandom_range(0, 3) != 0)) begin
               rq = make_request(FUNC_AAD, 0, 31);
               n_aad--;
            end else begin
               rq = make_request(FUNC_TEXT, 0, 31);
               n_text--;
            end
            if ($urandom_range(0, 9) < 6) rq.cnt = 16;
            items.push_back(rq);
            if ($urandom_range(0, 11) == 0)
               items.push_back(make_request(func_type'($urandom_range(0, 3)), 0, 0));
            if ($urandom_range(0, 15) == 0) items.push_back(make_request(FUNC_NONE, 0, 31));
         end
         items.push_back(finish_for(items));
         foreach (items[i]) begin
            pending_requests.push_back(items[i]);
            if (items[i].func == FUNC_FINISH || (items[i].func != FUNC_NONE && items[i].cnt != 0))
               used++;
         end
      end
   endtask

   // Edge cases under the reset configuration, then a decrypt pair
   task automatic directed_requests();
      request_type items [$];
      request_type rq;
      rq = '{FUNC_AAD, '1, '1, 5'd16};      items.push_back(rq);
      rq = '{FUNC_AAD, '1, '1, 5'd0};       items.push_back(rq);
      rq = '{FUNC_AAD, '1, '1, 5'd1};       items.push_back(rq);
      rq = '{FUNC_TEXT, '0, '0, 5'd16};     items.push_back(rq);
      rq = '{FUNC_TEXT, '1, '1, 5'd31};     items.push_back(rq);
      rq = '{FUNC_TEXT, '1, '0, 5'd5};      items.push_back(rq);
      rq = '{FUNC_NONE, '1, '1, 5'd16};     items.push_back(rq);
      rq = '{FUNC_AAD, '1, '1, 5'd9};       items.push_back(rq);
      rq = '{FUNC_TEXT, '1, '1, 5'd8};      items.push_back(rq);
      rq = '{FUNC_TEXT, '0, '1, 5'd0};      items.push_back(rq);
      rq = '{FUNC_FINISH, '1, '1, 5'd0};    items.push_back(rq);
      rq = '{FUNC_FINISH, '0, '0, 5'd31};   items.push_back(rq);
      foreach (items[i]) pending_requests.push_back(items[i]);
      wait_idle();
      write_csr(CSR_MODE, 64'd0);
      items.delete();
      rq = '{FUNC_AAD, 64'h0123456789abcdef, '1, 5'd12}; items.push_back(rq);
      rq = '{FUNC_TEXT, '1, 64'h55aa55aa55aa55aa, 5'd16}; items.push_back(rq);
      rq = '{FUNC_TEXT, 64'h8000000000000001, '1, 5'd3}; items.push_back(rq);
      rq = '{FUNC_FINISH, '0, '0, 5'd0};
      {rq.dh, rq.dl} = message_tag(items);
      items.push_back(rq);
      foreach (items[i]) pending_requests.push_back(items[i]);
      rq.dl[0] = ~rq.dl[0];
      pending_requests.push_back(rq);
      wait_idle();
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      fail_count = 0;
      responses_seen = 0;
      cycle_count = 0;
      build_sub_bytes();
      aes_key = '0;
      nonce = '0;
      encrypting = 1'b1;
      round_keys = expand_key(aes_key);
      gh_subkey = aes_encrypt('0);
      clear_message(msg);
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      directed_requests();

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               write_csr(CSR_KEY_HIGH, '1);
               write_csr(CSR_KEY_LOW, '1);
               write_csr(CSR_NONCE_HIGH, '1);
               write_csr(CSR_NONCE_LOW, '1);
               write_csr(CSR_MODE, 64'd0);
            end
            3: begin
               write_csr(CSR_KEY_HIGH, '0);
               write_csr(CSR_KEY_LOW, '0);
               write_csr(CSR_NONCE_HIGH, '0);
               write_csr(CSR_NONCE_LOW, '0);
               write_csr(CSR_MODE, 64'd1);
            end
            default: begin
               write_csr(CSR_KEY_HIGH, {$urandom, $urandom});
               write_csr(CSR_KEY_LOW, {$urandom, $urandom});
               write_csr(CSR_NONCE_HIGH, {$urandom, $urandom});
               write_csr(CSR_NONCE_LOW, {$urandom, $urandom});
               write_csr(CSR_MODE, {63'b0, phase == 1});
               // indexes past the last register must be ignored
               for (int i = CSR_MODE + 1; i < 8; i++) write_csr(3'(i), {$urandom, $urandom});
            end
         endcase
         random_messages(80);
         wait_idle();
      end

      if (fail_count == 0 && expected_responses.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
